FILE: sv/pvc_pkg.sv
package pvc_pkg;

    localparam logic [31:0] K_Q40     = 32'd2565774695;
    localparam logic [29:0] A_MIN     = 30'd33214047;
    localparam logic [29:0] A_CLAMP   = 30'd872569613;
    localparam logic [29:0] A_OFFSET  = 30'd28147498;
    localparam logic [29:0] A_SPAN    = 30'd844424930;
    localparam logic [15:0] V_MID     = 16'd16998;
    localparam logic [20:0] LN2_DIV6  = 21'd1938180;
    localparam logic [15:0] V_FULL    = 16'd40960;
    localparam logic [15:0] V_NEUTRAL = 16'd20480;

    localparam logic [19:0] ATM_RST  = 20'd101325;
    localparam logic [15:0] CRIT_RST = 16'd34079;
    localparam logic [15:0] LAM_RST  = 16'd65470;

    localparam logic [1:0] CFG_ATM  = 2'd0;
    localparam logic [1:0] CFG_CRIT = 2'd1;
    localparam logic [1:0] CFG_LAM  = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam int LOG_NORM = 5;
    localparam int LOG_FRAC = 20;
    localparam int LOG_LAT  = LOG_NORM + LOG_FRAC;

    typedef struct packed {
        logic [19:0] pu;
        logic [19:0] pd;
        logic [31:0] mag;
        logic        fill;
        logic        fault;
        logic        neut;
    } front_t;

    typedef struct packed {
        logic [19:0] pu;
        logic [19:0] pd;
        logic [31:0] mag;
        logic        fill;
        logic        fault;
        logic        neut;
        logic        lam;
        logic        clamp;
        logic        sat;
        logic        neg;
        logic [39:0] rem;
        logic [38:0] quo;
        logic [16:0] c;
        logic [32:0] sqv;
        logic [32:0] sqr;
        logic [43:0] t;
        logic [28:0] x16;
        logic [38:0] num;
        logic [38:0] d16;
        logic [29:0] u;
        logic [29:0] n;
        logic [14:0] term;
    } bk_t;

    typedef struct packed {
        logic [30:0] m;
        logic [24:0] res;
    } log_t;

endpackage

FILE: sv/pvc_req_if.sv
interface pvc_req_if;
    logic               valid;
    logic               ready;
    logic [19:0]        supply_pressure;
    logic [19:0]        chamber_pressure;
    logic signed [31:0] target_flow;
    logic               active_source;

    modport source (output valid, output supply_pressure, output chamber_pressure,
                    output target_flow, output active_source, input ready);
    modport sink (input valid, input supply_pressure, input chamber_pressure,
                  input target_flow, input active_source, output ready);
endinterface

FILE: sv/pvc_cmd_if.sv
interface pvc_cmd_if;
    logic        valid;
    logic        ready;
    logic [15:0] valve_voltage;
    logic        pressure_fault;

    modport source (output valid, output valve_voltage, output pressure_fault, input ready);
    modport sink (input valid, input valve_voltage, input pressure_fault, output ready);
endinterface

FILE: sv/pvc_front.sv
module pvc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [19:0]    atm,
    pvc_req_if.sink        request,
    output pvc_pkg::front_t fr_data,
    output logic           fr_valid,
    input  logic           fr_ready
);
    import pvc_pkg::*;

    front_t      cls;
    front_t      data_reg;
    logic        valid_reg;
    logic        take;
    logic        negf;
    logic [31:0] raw;

    assign request.ready = !valid_reg || fr_ready;
    assign take = request.valid && request.ready;

    always_comb
    begin
        raw = request.target_flow;
        negf = raw[31];
        cls.fill = !negf && (raw != 32'd0);
        cls.mag = negf ? (~raw + 32'd1) : raw;
        if (request.chamber_pressure >= atm)
        begin
            cls.pu = cls.fill ? request.supply_pressure : request.chamber_pressure;
            cls.pd = cls.fill ? request.chamber_pressure : atm;
        end
        else if (cls.fill)
        begin
            cls.pu = request.active_source ? request.supply_pressure : atm;
            cls.pd = request.chamber_pressure;
        end
        else
        begin
            cls.pu = request.chamber_pressure;
            cls.pd = 20'd0;
        end
        cls.fault = (cls.pu == 20'd0);
        cls.neut = (cls.pd >= cls.pu) || (cls.mag == 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (fr_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= cls;
        end
    end

    assign fr_data = data_reg;
    assign fr_valid = valid_reg;
endmodule

FILE: sv/pvc_queue.sv
module pvc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  pvc_pkg::front_t wr_data,
    input  logic            wr_valid,
    output logic            wr_ready,
    output pvc_pkg::front_t rd_data,
    output logic            rd_valid,
    input  logic            rd_ready
);
    import pvc_pkg::*;

    front_t            q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != (QPTR_W + 1)'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_data = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= wr_data;
        end
    end
endmodule

FILE: sv/pvc_log2.sv
module pvc_log2 (
    input  logic        clk,
    input  logic        en,
    input  logic [29:0] x,
    output logic [24:0] res
);
    import pvc_pkg::*;

    log_t lg_reg [LOG_LAT];

    genvar j;
    generate
        for (j = 0; j < LOG_LAT; j++)
        begin : g_stage
            log_t a;
            log_t o;
            if (j == 0)
            begin : g_first
                assign a = '{m: {1'b0, x}, res: '0};
            end
            else
            begin : g_next
                assign a = lg_reg[j-1];
            end

            if (j < LOG_NORM)
            begin : g_norm
                localparam int SH = 16 >> j;
                always_comb
                begin
                    o = a;
                    if (a.m[30 -: SH] == '0)
                    begin
                        o.m = a.m << SH;
                        o.res = a.res + 25'(SH);
                    end
                end
            end
            else
            begin : g_sq
                localparam int BI = LOG_FRAC - 1 - (j - LOG_NORM);
                logic [24:0] r0;
                logic [61:0] p;
                logic [31:0] pt;
                always_comb
                begin
                    if (j == LOG_NORM)
                    begin
                        r0 = {5'd30 - a.res[4:0], 20'd0};
                    end
                    else
                    begin
                        r0 = a.res;
                    end
                    p = 62'(a.m) * 62'(a.m);
                    pt = p[61:30];
                    o.res = r0;
                    if (pt[31])
                    begin
                        o.m = pt[31:1];
                        o.res[BI] = 1'b1;
                    end
                    else
                    begin
                        o.m = pt[30:0];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lg_reg[j] <= o;
                end
            end
        end
    endgenerate

    assign res = lg_reg[LOG_LAT-1].res;
endmodule

FILE: sv/pvc_back.sv
module pvc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     crit_ratio,
    input  logic [15:0]     lam_ratio,
    input  pvc_pkg::front_t head,
    input  logic            head_valid,
    output logic            head_ready,
    pvc_cmd_if.source       command
);
    import pvc_pkg::*;

    localparam int REG_S = 16;
    localparam int SQ_S  = 33;
    localparam int RT0   = 34;
    localparam int TK_S  = 51;
    localparam int TF_S  = 52;
    localparam int LP_S  = 53;
    localparam int AP_S  = 93;
    localparam int AR_S  = 124;
    localparam int TM_S  = AR_S + LOG_LAT + 1;
    localparam int NSTG  = TM_S + 1;

    bk_t             stg_reg [NSTG];
    bk_t             stg_in  [NSTG];
    logic [NSTG-1:0] vld_reg;
    logic            adv;
    logic            ov_reg;
    logic [15:0]     vv_reg;
    logic            pf_reg;
    logic [15:0]     v_next;
    logic [24:0]     ln;
    logic [24:0]     lu;

    function automatic bk_t step(input int k, input bk_t a, input logic [15:0] b,
                                 input logic [15:0] bl, input logic [24:0] lnv,
                                 input logic [24:0] luv);
        bk_t         o;
        logic [20:0] r21;
        logic [17:0] r18;
        logic [39:0] r40;
        logic [15:0] pr;
        logic [15:0] dv;
        logic [31:0] xx;
        logic [32:0] bit33;
        logic [32:0] rb;
        logic [19:0] base;
        logic [51:0] p52;
        logic [60:0] p61;
        logic [29:0] ar;
        logic [24:0] diff;
        logic [46:0] p47;
        o = a;
        if (k < REG_S)
        begin
            r21 = {a.rem[19:0], 1'b0};
            if (r21 >= {1'b0, a.pu})
            begin
                o.rem = 40'(r21 - {1'b0, a.pu});
                o.quo = {a.quo[37:0], 1'b1};
            end
            else
            begin
                o.rem = 40'(r21);
                o.quo = {a.quo[37:0], 1'b0};
            end
        end
        else if (k == REG_S)
        begin
            pr = a.quo[15:0];
            o.lam = 1'b0;
            dv = 16'd0;
            if (pr < b)
            begin
                dv = 16'd0;
            end
            else if (pr < bl)
            begin
                dv = pr - b;
            end
            else
            begin
                o.lam = 1'b1;
                dv = (bl > b) ? (bl - b) : 16'd0;
            end
            o.c = 17'h10000 - {1'b0, b};
            o.rem = 40'(dv);
            o.quo = '0;
        end
        else if (k < SQ_S)
        begin
            r18 = {a.rem[16:0], 1'b0};
            if (r18 >= {1'b0, a.c})
            begin
                o.rem = 40'(r18 - {1'b0, a.c});
                o.quo = {a.quo[37:0], 1'b1};
            end
            else
            begin
                o.rem = 40'(r18);
                o.quo = {a.quo[37:0], 1'b0};
            end
        end
        else if (k == SQ_S)
        begin
            xx = 32'(a.quo[15:0]) * 32'(a.quo[15:0]);
            o.sqv = 33'h1_0000_0000 - {1'b0, xx};
            o.sqr = '0;
        end
        else if (k < TK_S)
        begin
            bit33 = 33'd1 << (32 - 2 * (k - RT0));
            rb = a.sqr + bit33;
            if (a.sqv >= rb)
            begin
                o.sqv = a.sqv - rb;
                o.sqr = (a.sqr >> 1) + bit33;
            end
            else
            begin
                o.sqr = a.sqr >> 1;
            end
        end
        else if (k == TK_S)
        begin
            base = a.lam ? (a.pu - a.pd) : a.pu;
            p52 = 52'(K_Q40) * 52'(base);
            o.t = p52[51:8];
        end
        else if (k == TF_S)
        begin
            p61 = 61'(a.t) * 61'(a.sqr[16:0]);
            o.x16 = p61[60:32];
        end
        else if (k == LP_S)
        begin
            o.c = 17'h10000 - {1'b0, bl};
            o.sat = ({11'd0, a.x16[28:23]} >= o.c);
            o.rem = 40'(a.x16[28:23]);
            o.num = {a.x16[22:0], 16'd0};
            o.quo = '0;
            o.d16 = 39'(a.x16);
        end
        else if (k < AP_S)
        begin
            if (a.lam)
            begin
                r18 = {a.rem[16:0], a.num[38]};
                o.num = {a.num[37:0], 1'b0};
                if (r18 >= {1'b0, a.c})
                begin
                    o.rem = 40'(r18 - {1'b0, a.c});
                    o.quo = {a.quo[37:0], 1'b1};
                end
                else
                begin
                    o.rem = 40'(r18);
                    o.quo = {a.quo[37:0], 1'b0};
                end
            end
        end
        else if (k == AP_S)
        begin
            if (a.lam)
            begin
                o.d16 = a.sat ? '1 : a.quo;
            end
            o.clamp = ({5'd0, a.mag, 2'b00} >= o.d16);
            o.rem = {6'd0, a.mag, 2'b00};
            o.quo = '0;
        end
        else if (k < AR_S)
        begin
            r40 = {a.rem[38:0], 1'b0};
            if (r40 >= {1'b0, a.d16})
            begin
                o.rem = r40 - {1'b0, a.d16};
                o.quo = {a.quo[37:0], 1'b1};
            end
            else
            begin
                o.rem = r40;
                o.quo = {a.quo[37:0], 1'b0};
            end
        end
        else if (k == AR_S)
        begin
            ar = (a.clamp || (a.quo[29:0] > A_CLAMP)) ? A_CLAMP : a.quo[29:0];
            if (ar < A_MIN)
            begin
                o.neut = 1'b1;
            end
            o.u = ar - A_OFFSET;
            o.n = A_SPAN - o.u;
        end
        else if (k == TM_S)
        begin
            o.neg = (luv > lnv);
            diff = o.neg ? (luv - lnv) : (lnv - luv);
            p47 = 47'(diff) * 47'(LN2_DIV6) + 47'h8000_0000;
            o.term = p47[46:32];
        end
        return o;
    endfunction

    assign adv = !ov_reg || command.ready;
    assign head_ready = adv;

    pvc_log2 u_log_n (
        .clk (clk),
        .en  (adv),
        .x   (stg_reg[AR_S].n),
        .res (ln)
    );

    pvc_log2 u_log_u (
        .clk (clk),
        .en  (adv),
        .x   (stg_reg[AR_S].u),
        .res (lu)
    );

    genvar k;
    generate
        for (k = 0; k < NSTG; k++)
        begin : g_stage
            if (k == 0)
            begin : g_first
                always_comb
                begin
                    stg_in[k] = '0;
                    stg_in[k].pu = head.pu;
                    stg_in[k].pd = head.pd;
                    stg_in[k].mag = head.mag;
                    stg_in[k].fill = head.fill;
                    stg_in[k].fault = head.fault;
                    stg_in[k].neut = head.neut;
                    stg_in[k].rem = 40'(head.pd);
                end
            end
            else
            begin : g_next
                assign stg_in[k] = stg_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    stg_reg[k] <= step(k, stg_in[k], crit_ratio, lam_ratio, ln, lu);
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (stg_reg[TM_S].neg)
        begin
            v_next = (16'(stg_reg[TM_S].term) > V_MID) ? 16'd0
                                                        : V_MID - 16'(stg_reg[TM_S].term);
        end
        else
        begin
            v_next = V_MID + 16'(stg_reg[TM_S].term);
        end
        if (v_next > V_FULL)
        begin
            v_next = V_FULL;
        end
        if (!stg_reg[TM_S].fill)
        begin
            v_next = V_FULL - v_next;
        end
        if (stg_reg[TM_S].neut)
        begin
            v_next = V_NEUTRAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], head_valid};
            ov_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vv_reg <= v_next;
            pf_reg <= stg_reg[TM_S].fault;
        end
    end

    assign command.valid = ov_reg;
    assign command.valve_voltage = vv_reg;
    assign command.pressure_fault = pf_reg;
endmodule

FILE: sv/pneumatic_valve_command_from_flow.sv
// An accepted request word passes the front register, the queue and the back pipeline to its
// command word. Throughput is one word per cycle while the command output is not stalled;
// most back stages are divider or square root bit steps, log unit steps or multipliers.
// A four-word queue between the front register and the back pipeline decouples the two sides.
// Reset clears all valid bits and the queue and loads the default register values.
module pneumatic_valve_command_from_flow (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    pvc_req_if.sink     request,
    pvc_cmd_if.source   command
);
    import pvc_pkg::*;

    logic [19:0] atm_reg;
    logic [15:0] crit_reg;
    logic [15:0] lam_reg;
    front_t      fr_data;
    logic        fr_valid;
    logic        fr_ready;
    front_t      hd_data;
    logic        hd_valid;
    logic        hd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atm_reg <= ATM_RST;
            crit_reg <= CRIT_RST;
            lam_reg <= LAM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ATM:  atm_reg <= cfg_data;
                CFG_CRIT: crit_reg <= cfg_data[15:0];
                CFG_LAM:  lam_reg <= cfg_data[15:0];
                default:  ;
            endcase
        end
    end

    pvc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .atm      (atm_reg),
        .request  (request),
        .fr_data  (fr_data),
        .fr_valid (fr_valid),
        .fr_ready (fr_ready)
    );

    pvc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (fr_data),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .rd_data  (hd_data),
        .rd_valid (hd_valid),
        .rd_ready (hd_ready)
    );

    pvc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .crit_ratio (crit_reg),
        .lam_ratio  (lam_reg),
        .head       (hd_data),
        .head_valid (hd_valid),
        .head_ready (hd_ready),
        .command    (command)
    );
endmodule
